FILE: rtl/hcbe_pkg.sv
`timescale 1ns / 1ps

package hcbe_pkg;

  // Default largest block order.
  localparam int DEF_MAX_ORDER = 4;

  // Key matrix rows and columns that the registers hold.
  localparam int KEY_DIM = 4;

  // Symbol and register widths.
  localparam int SYM_W  = 8;
  localparam int BS_W   = 3;
  localparam int KEY_W  = 32;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register reset values.
  localparam logic [SYM_W-1:0] MODULUS_RST    = 8'd26;
  localparam logic [BS_W-1:0]  BLOCK_SIZE_RST = 3'd2;
  localparam logic [SYM_W-1:0] PAD_SYMBOL_RST = 8'd25;

  // Register indexes, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_MODULUS    = 3'd0,
    REG_BLOCK_SIZE = 3'd1,
    REG_PAD_SYMBOL = 3'd2,
    REG_KEY_ROW0   = 3'd3,
    REG_KEY_ROW1   = 3'd4,
    REG_KEY_ROW2   = 3'd5,
    REG_KEY_ROW3   = 3'd6
  } reg_idx_t;

  typedef logic [KEY_W-1:0] key_rows_t [KEY_DIM];

  // Key entry at row x, column y; entries beyond the packed rows read as zero.
  function automatic logic [SYM_W-1:0] key_pick(input key_rows_t rows,
                                                input logic [3:0] x,
                                                input logic [3:0] y);
    logic [SYM_W-1:0] val;
    val = '0;
    if (x < 4'(KEY_DIM) && y < 4'(KEY_DIM)) begin
      val = rows[x[1:0]][{y[1:0], 3'b000} +: SYM_W];
    end
    return val;
  endfunction

endpackage

FILE: rtl/hcbe_mac.sv
`timescale 1ns / 1ps

module hcbe_mac
  import hcbe_pkg::*;
#(
  parameter int ACC_W = 19
) (
  input  logic             clk,
  input  logic             clr,
  input  logic             en,
  input  logic [SYM_W-1:0] key_byte,
  input  logic [SYM_W-1:0] sym,
  output logic [ACC_W-1:0] acc
);

  logic [2*SYM_W-1:0] prod;

  assign prod = key_byte * sym;

  // One product per cycle is added into the row sum while en is high.
  always_ff @(posedge clk) begin
    if (clr) begin
      acc <= '0;
    end else if (en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

FILE: rtl/hcbe_mod.sv
`timescale 1ns / 1ps

module hcbe_mod
  import hcbe_pkg::*;
#(
  parameter int DIV_W = 19
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [SYM_W-1:0] modulus,
  output logic             done,
  output logic [SYM_W-1:0] rem
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] shreg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [SYM_W:0]   trial;
  logic             fits;

  // Bring in the next dividend bit and test it against the modulus.
  assign trial = {rem, shreg[DIV_W-1]};
  assign fits  = trial >= {1'b0, modulus};

  // Restoring remainder, one dividend bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(DIV_W);
        shreg <= dividend;
        rem   <= '0;
      end else if (busy) begin
        shreg <= shreg << 1;
        rem   <= fits ? SYM_W'(trial - {1'b0, modulus}) : trial[SYM_W-1:0];
        cnt   <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/hill_cipher_block_encrypt.sv
`timescale 1ns / 1ps

// Channel  | Dir | Fields (low bit up)                      | Item accepted when
// s_t*     | in  | tdata: symbol[7:0]; tlast: message_end    | s_tvalid & s_tready
// m_t*     | out | tdata: out_symbol[7:0]; tuser: block_last;| m_tvalid & m_tready
//          |     | tlast: message_last                       |
// APB      | in  | paddr 4*index, pwdata 32 bits             | psel&penable&pwrite
//
// An item that does not close a block leaves s_tready high. An item that
// closes a block of order n starts n rows, each worked by the single
// multiply-accumulate unit and, with a nonzero modulus, the bit-serial
// remainder unit; a zero modulus skips the remainder unit (ACC_W = 19 at the
// default order of 4). Reset clears the sequencer and loads the register
// defaults. s_tready is low from the item that closes a block until the block's
// last cipher symbol is taken; a low m_tready holds the sequencer.

module hill_cipher_block_encrypt
  import hcbe_pkg::*;
#(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic              clk,
  input  logic              rst,
  // Plaintext stream.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // symbol[7:0]
  input  logic              s_tlast,   // message_end
  // Ciphertext stream.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // out_symbol[7:0]
  output logic              m_tuser,   // block_last
  output logic              m_tlast,   // message_last
  // Register port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int ORD_W = $clog2(MAX_ORDER + 1);
  localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int ACC_W = 2 * SYM_W + $clog2(MAX_ORDER) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_RED,
    S_WAIT,
    S_OUT
  } state_t;

  // Configuration registers.
  logic [SYM_W-1:0] modulus;
  logic [BS_W-1:0]  block_size;
  logic [SYM_W-1:0] pad_symbol;
  key_rows_t        key_row;

  // Gathered symbols and sequencer state.
  logic [SYM_W-1:0] block_store [MAX_ORDER];
  logic [BS_W-1:0]  fill_count;
  logic [BS_W-1:0]  valid_count;
  logic             msg_end;
  state_t           state;
  logic [ORD_W-1:0] row;
  logic [ORD_W-1:0] col;

  logic [ORD_W-1:0] order;
  logic [BS_W-1:0]  fill_base;
  logic [BS_W-1:0]  fill_next;
  logic             in_acc;
  logic             closes;
  logic             row_last;
  logic [SYM_W-1:0] operand;
  logic [SYM_W-1:0] key_byte;
  logic [ACC_W-1:0] acc;
  logic [SYM_W-1:0] rem;
  logic             mod_start;
  logic             mod_done;
  logic             cfg_wr;

  // Effective order: zero acts as one, large values saturate.
  always_comb begin
    if (block_size == '0) begin
      order = ORD_W'(1);
    end else if (4'(block_size) > 4'(MAX_ORDER)) begin
      order = ORD_W'(MAX_ORDER);
    end else begin
      order = ORD_W'(block_size);
    end
  end

  // A stale count from a larger order restarts gathering.
  assign fill_base = (4'(fill_count) >= 4'(order)) ? '0 : fill_count;
  assign fill_next = fill_base + 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign closes    = (4'(fill_next) >= 4'(order)) || s_tlast;
  assign row_last  = (row == order - 1'b1);

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);

  // Operand for this column: gathered symbol, or pad past the fill point.
  assign operand  = (4'(col) < 4'(valid_count)) ? block_store[col[IDX_W-1:0]]
                                                : pad_symbol;
  assign key_byte = key_pick(key_row, 4'(row), 4'(col));

  assign mod_start = (state == S_RED) && (modulus != '0);

  hcbe_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk      (clk),
    .clr      ((state == S_IDLE) || (state == S_OUT)),
    .en       (state == S_MAC),
    .key_byte (key_byte),
    .sym      (operand),
    .acc      (acc)
  );

  hcbe_mod #(
    .DIV_W (ACC_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (acc),
    .modulus  (modulus),
    .done     (mod_done),
    .rem      (rem)
  );

  // Register writes and read-back.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus    <= MODULUS_RST;
      block_size <= BLOCK_SIZE_RST;
      pad_symbol <= PAD_SYMBOL_RST;
      key_row    <= '{default: '0};
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_MODULUS:    modulus    <= pwdata[SYM_W-1:0];
        REG_BLOCK_SIZE: block_size <= pwdata[BS_W-1:0];
        REG_PAD_SYMBOL: pad_symbol <= pwdata[SYM_W-1:0];
        REG_KEY_ROW0:   key_row[0] <= pwdata;
        REG_KEY_ROW1:   key_row[1] <= pwdata;
        REG_KEY_ROW2:   key_row[2] <= pwdata;
        REG_KEY_ROW3:   key_row[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MODULUS:    prdata = DATA_W'(modulus);
      REG_BLOCK_SIZE: prdata = DATA_W'(block_size);
      REG_PAD_SYMBOL: prdata = DATA_W'(pad_symbol);
      REG_KEY_ROW0:   prdata = key_row[0];
      REG_KEY_ROW1:   prdata = key_row[1];
      REG_KEY_ROW2:   prdata = key_row[2];
      REG_KEY_ROW3:   prdata = key_row[3];
      default:        prdata = '0;
    endcase
  end

  // Symbol store, written at the fill point.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      block_store[fill_base[IDX_W-1:0]] <= s_tdata;
    end
  end

  // Sequencer: gather, then per row accumulate, reduce and emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      row        <= '0;
      col        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (closes) begin
              fill_count  <= '0;
              valid_count <= fill_next;
              msg_end     <= s_tlast;
              row         <= '0;
              col         <= '0;
              state       <= S_MAC;
            end else begin
              fill_count <= fill_next;
            end
          end
        end
        S_MAC: begin
          col <= col + 1'b1;
          if (col == order - 1'b1) begin
            state <= S_RED;
          end
        end
        S_RED: begin
          if (modulus == '0) begin
            m_tdata <= acc[SYM_W-1:0];
            m_tuser <= row_last;
            m_tlast <= row_last && msg_end;
            state   <= S_OUT;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mod_done) begin
            m_tdata <= rem;
            m_tuser <= row_last;
            m_tlast <= row_last && msg_end;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            if (row_last) begin
              state <= S_IDLE;
            end else begin
              row   <= row + 1'b1;
              col   <= '0;
              state <= S_MAC;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
